// ===== rtl/sfla_pkg.sv =====
package sfla_pkg;

    // Default pool size; the top level takes it as its parameter default.
    localparam int POOL_SLOTS_DEF = 64;

    // Fixed payload widths of the words on the two channels.
    localparam int HANDLE_W = 7;
    localparam int STATUS_W = 3;

    // Request codes carried on the action input.
    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 3'd0,
        ST_FULL    = 3'd1,
        ST_ZERO    = 3'd2,
        ST_RANGE   = 3'd3,
        ST_ALREADY = 3'd4
    } status_t;

    // One finished result, handed from the controller to the output register.
    typedef struct packed {
        logic [HANDLE_W-1:0] granted;
        status_t             status;
    } result_t;

endpackage

// ===== rtl/sfla_link_ram.sv =====
module sfla_link_ram
    import sfla_pkg::*;
#(
    parameter int DEPTH  = POOL_SLOTS_DEF,
    parameter int ADDR_W = $clog2(POOL_SLOTS_DEF),
    parameter int DATA_W = $clog2(POOL_SLOTS_DEF + 1)
)
(
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    // Link memory: one write port, one read port with registered data.
    logic [DATA_W-1:0] link_mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            link_mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= link_mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/sfla_ctrl.sv =====
module sfla_ctrl
    import sfla_pkg::*;
#(
    parameter int POOL_SLOTS = POOL_SLOTS_DEF
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic                                   action,
    input  logic [HANDLE_W-1:0]                    handle,
    output logic                                   res_valid,
    input  logic                                   res_ready,
    output result_t                                res,
    output logic                                   mem_we,
    output logic [$clog2(POOL_SLOTS)-1:0]          mem_waddr,
    output logic [$clog2(POOL_SLOTS + 1)-1:0]      mem_wdata,
    output logic                                   mem_re,
    output logic [$clog2(POOL_SLOTS)-1:0]          mem_raddr,
    input  logic [$clog2(POOL_SLOTS + 1)-1:0]      mem_rdata
);

    localparam int ADDR_W = $clog2(POOL_SLOTS);
    localparam int SLOT_W = $clog2(POOL_SLOTS + 1);
    localparam int CMP_W  = (SLOT_W > HANDLE_W) ? SLOT_W : HANDLE_W;

    typedef enum logic [5:0] {
        S_INIT     = 6'b000001,
        S_IDLE     = 6'b000010,
        S_ALLOC_RD = 6'b000100,
        S_WALK     = 6'b001000,
        S_LINK     = 6'b010000,
        S_EMIT     = 6'b100000
    } state_t;

    state_t              state_reg, state_next;
    logic [SLOT_W-1:0]   head_reg, head_next;
    logic [SLOT_W-1:0]   idx_reg, idx_next;
    logic [SLOT_W-1:0]   walk_reg, walk_next;
    logic [ADDR_W-1:0]   init_cnt_reg, init_cnt_next;
    result_t             res_reg, res_next;

    logic [CMP_W-1:0]    handle_c;
    logic [CMP_W-1:0]    idx_c;
    logic [CMP_W-1:0]    head_c;
    logic                accept;

    assign handle_c = CMP_W'(handle);
    assign idx_c    = handle_c - CMP_W'(1);
    assign head_c   = CMP_W'(head_reg);
    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        state_next    = state_reg;
        head_next     = head_reg;
        idx_next      = idx_reg;
        walk_next     = walk_reg;
        init_cnt_next = init_cnt_reg;
        res_next      = res_reg;
        mem_we        = 1'b0;
        mem_waddr     = '0;
        mem_wdata     = '0;
        mem_re        = 1'b0;
        mem_raddr     = '0;

        case (state_reg)
            S_INIT:
            begin
                mem_we    = 1'b1;
                mem_waddr = init_cnt_reg;
                mem_wdata = SLOT_W'(init_cnt_reg) + SLOT_W'(1);
                if (init_cnt_reg == ADDR_W'(POOL_SLOTS - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    init_cnt_next = init_cnt_reg + ADDR_W'(1);
                end
            end

            S_IDLE:
            begin
                if (accept)
                begin
                    if (action == ACT_ALLOC)
                    begin
                        if (head_reg == SLOT_W'(POOL_SLOTS))
                        begin
                            res_next   = '{granted: '0, status: ST_FULL};
                            state_next = S_EMIT;
                        end
                        else
                        begin
                            mem_re     = 1'b1;
                            mem_raddr  = head_reg[ADDR_W-1:0];
                            state_next = S_ALLOC_RD;
                        end
                    end
                    else if (handle_c == '0)
                    begin
                        res_next   = '{granted: '0, status: ST_ZERO};
                        state_next = S_EMIT;
                    end
                    else if (handle_c > CMP_W'(POOL_SLOTS))
                    begin
                        res_next   = '{granted: '0, status: ST_RANGE};
                        state_next = S_EMIT;
                    end
                    else if (head_c == idx_c)
                    begin
                        res_next   = '{granted: '0, status: ST_ALREADY};
                        state_next = S_EMIT;
                    end
                    else if (head_c > idx_c)
                    begin
                        // The freed slot becomes the new head of the chain.
                        mem_we     = 1'b1;
                        mem_waddr  = idx_c[ADDR_W-1:0];
                        mem_wdata  = head_reg;
                        head_next  = SLOT_W'(idx_c);
                        res_next   = '{granted: '0, status: ST_OK};
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        mem_re     = 1'b1;
                        mem_raddr  = head_reg[ADDR_W-1:0];
                        walk_next  = head_reg;
                        idx_next   = SLOT_W'(idx_c);
                        state_next = S_WALK;
                    end
                end
            end

            S_ALLOC_RD:
            begin
                head_next  = mem_rdata;
                res_next   = '{granted: HANDLE_W'(head_reg + SLOT_W'(1)), status: ST_OK};
                state_next = S_EMIT;
            end

            S_WALK:
            begin
                // walk_reg holds the predecessor, mem_rdata its successor.
                if (mem_rdata < idx_reg)
                begin
                    mem_re    = 1'b1;
                    mem_raddr = mem_rdata[ADDR_W-1:0];
                    walk_next = mem_rdata;
                end
                else if (mem_rdata == idx_reg)
                begin
                    res_next   = '{granted: '0, status: ST_ALREADY};
                    state_next = S_EMIT;
                end
                else
                begin
                    mem_we     = 1'b1;
                    mem_waddr  = walk_reg[ADDR_W-1:0];
                    mem_wdata  = idx_reg;
                    walk_next  = mem_rdata;
                    state_next = S_LINK;
                end
            end

            S_LINK:
            begin
                mem_we     = 1'b1;
                mem_waddr  = idx_reg[ADDR_W-1:0];
                mem_wdata  = walk_reg;
                res_next   = '{granted: '0, status: ST_OK};
                state_next = S_EMIT;
            end

            S_EMIT:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_INIT;
            head_reg     <= '0;
            init_cnt_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            head_reg     <= head_next;
            init_cnt_reg <= init_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        walk_reg <= walk_next;
        res_reg  <= res_next;
    end

    assign res_valid = (state_reg == S_EMIT);
    assign res       = res_reg;

endmodule

// ===== rtl/sorted_free_list_handle_allocator_core.sv =====
// Flow: a word that fails at once, or a free whose slot becomes the new head, goes from the
// idle state to S_EMIT and then into the output register; an allocate that grants first reads
// the head's link in S_ALLOC_RD, and a free that walks the chain reads one link per S_WALK step
// and writes in S_LINK when it links a slot in. Throughput: one word at a time, since in_stall
// stays high until the result of the last word is handed over. Reset: asynchronous, active low;
// afterwards a sweep writes the POOL_SLOTS links of the initial chain while in_stall stays high.
module sorted_free_list_handle_allocator_core
    import sfla_pkg::*;
#(
    parameter int POOL_SLOTS = POOL_SLOTS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                action,
    input  logic [HANDLE_W-1:0] handle,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [HANDLE_W-1:0] granted_handle,
    output logic [STATUS_W-1:0] status
);

    // The free slots form a singly linked chain in ascending order that ends at the value
    // POOL_SLOTS. The head of the chain sits in a register inside the controller; the links
    // sit in a synchronous memory with one write and one read port.
    localparam int ADDR_W = $clog2(POOL_SLOTS);
    localparam int SLOT_W = $clog2(POOL_SLOTS + 1);

    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [SLOT_W-1:0] mem_wdata;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_raddr;
    logic [SLOT_W-1:0] mem_rdata;

    logic              res_valid;
    logic              res_ready;
    result_t           res;

    logic                out_valid_reg, out_valid_next;
    logic [HANDLE_W-1:0] granted_reg;
    status_t             status_reg;
    logic                load;

    sfla_link_ram #(
        .DEPTH  (POOL_SLOTS),
        .ADDR_W (ADDR_W),
        .DATA_W (SLOT_W)
    ) u_link_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // The controller runs the reset sweep, pops the head on an allocate and walks the
    // chain on a free. Every memory access of one word happens in its own cycle and the
    // next word is taken only after the last write, so reads never race writes.
    sfla_ctrl #(
        .POOL_SLOTS (POOL_SLOTS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .action    (action),
        .handle    (handle),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    // Output register: it takes a new result when it is empty or when its word leaves in the
    // same cycle, so the controller can go on with the next word while a result waits.
    assign res_ready = !out_valid_reg || !out_stall;
    assign load      = res_valid && res_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            granted_reg <= res.granted;
            status_reg  <= res.status;
        end
    end

    assign out_valid      = out_valid_reg;
    assign granted_handle = granted_reg;
    assign status         = status_reg;

    // A granted handle only comes with a good status.
    a_grant_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (granted_reg == '0 || status_reg == ST_OK))
        else $error("nonzero handle with a failing status");

    // Once a word is taken the controller is busy in the next cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input taken again right after an accept");

    // A result handed over is visible at the output in the next cycle.
    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> out_valid_reg)
        else $error("loaded result not presented");

endmodule
